FILE: hdl/u8rs_pkg.sv
// Shared types and constants for the UTF-8 code point run splitter.
// Used by u8rs_decode, u8rs_run_fifo and utf8_code_point_run_splitter.
package u8rs_pkg;

    // Configuration register index width and register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MATCH_CODE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MATCH_MASK = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANGE_FLAG = 2'd2;

    // Lead byte patterns and payload masks.
    localparam logic [7:0] LEAD_ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD_2_MASK     = 8'hC0;
    localparam logic [7:0] LEAD_3_MASK     = 8'hE0;
    localparam logic [7:0] LEAD_4_MASK     = 8'hF0;
    localparam logic [7:0] LEAD_5_MASK     = 8'hF8;
    localparam logic [7:0] BITS_6          = 8'h3F;
    localparam logic [7:0] BITS_5          = 8'h1F;
    localparam logic [7:0] BITS_4          = 8'h0F;
    localparam logic [7:0] BITS_3          = 8'h07;

    // Depth of the result queue; it must hold two items from one byte.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    // One input item: a text byte and its end marker.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    // One result item: a closed run.
    typedef struct packed {
        logic [31:0] run_offset;
        logic [31:0] run_bytes;
        logic [31:0] run_tag;
        logic        final_run;
    } t_out_item;

    // Results produced by one processed byte, in order.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  first;
        t_out_item  second;
    } t_push;

endpackage

FILE: hdl/u8rs_decode.sv
// Input register, configuration registers, UTF-8 decode and run tracking.
// Depends on u8rs_pkg; feeds its results to u8rs_run_fifo.
module u8rs_decode
    import u8rs_pkg::*;
#(
    parameter int POSITION_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  t_in_item                  i_in_item,
    output logic                      o_in_stall,
    input  logic                      i_cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [31:0]               i_cfg_data,
    input  logic                      i_room,
    output t_push                     o_push
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // Input register.
    logic     r_in_valid;
    t_in_item r_in_item;

    // Configuration registers.
    logic [31:0] r_match_code;
    logic [31:0] r_match_mask;
    logic [31:0] r_range_flag;

    // Text state.
    logic [POSITION_BITS-1:0] r_text_position, n_text_position;
    logic [POSITION_BITS-1:0] r_run_begin, n_run_begin;
    logic [POSITION_BITS-1:0] r_point_begin, n_point_begin;
    logic [31:0]              r_point_value, n_point_value;
    logic [2:0]               r_bytes_pending, n_bytes_pending;
    logic                     r_prior_match, n_prior_match;
    logic                     r_first_done, n_first_done;

    logic                     w_proceed;
    logic                     w_load;
    logic [7:0]               w_byte;
    logic                     w_eot;
    logic [31:0]              w_value;
    logic [2:0]               w_pending;
    logic [POSITION_BITS-1:0] w_point_begin;
    logic [POSITION_BITS:0]   w_inc;
    logic [POSITION_BITS-1:0] w_pos;
    logic [POSITION_BITS:0]   w_end_sum;
    logic [POSITION_BITS-1:0] w_end;
    logic                     w_complete;
    logic                     w_match;
    logic                     w_split;
    logic [POSITION_BITS-1:0] w_run_begin;
    logic                     w_prior;
    t_out_item                w_split_run;
    t_out_item                w_final_run;

    // The held byte is processed when the queue can take two results.
    assign w_proceed  = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;
    assign w_load     = i_in_valid && !o_in_stall;
    assign w_byte     = r_in_item.text_byte;
    assign w_eot      = r_in_item.end_of_text;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load) begin
            r_in_valid <= 1'b1;
        end else if (w_proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_item <= i_in_item;
        end
    end

    // Configuration writes; an unused index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_code <= '0;
            r_match_mask <= '0;
            r_range_flag <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MATCH_CODE: r_match_code <= i_cfg_data;
                CFG_MATCH_MASK: r_match_mask <= i_cfg_data;
                CFG_RANGE_FLAG: r_range_flag <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lead byte decode or continuation accumulate.
    always_comb begin
        w_point_begin = r_point_begin;
        w_value       = r_point_value;
        w_pending     = r_bytes_pending;
        if (r_bytes_pending == 3'd0) begin
            w_point_begin = r_text_position;
            if ((w_byte & LEAD_ASCII_MASK) == 8'h00) begin
                w_value   = {24'h0, w_byte};
                w_pending = 3'd0;
            end else if ((w_byte & LEAD_5_MASK) == LEAD_5_MASK) begin
                w_value   = {24'h0, w_byte & BITS_3};
                w_pending = 3'd4;
            end else if ((w_byte & LEAD_4_MASK) == LEAD_4_MASK) begin
                w_value   = {24'h0, w_byte & BITS_4};
                w_pending = 3'd3;
            end else if ((w_byte & LEAD_3_MASK) == LEAD_3_MASK) begin
                w_value   = {24'h0, w_byte & BITS_5};
                w_pending = 3'd2;
            end else if ((w_byte & LEAD_2_MASK) == LEAD_2_MASK) begin
                w_value   = {24'h0, w_byte & BITS_6};
                w_pending = 3'd1;
            end else begin
                // A stray continuation byte stands alone as all ones.
                w_value   = 32'hFFFF_FFFF;
                w_pending = 3'd0;
            end
        end else begin
            w_value   = {r_point_value[25:0], w_byte[5:0]};
            w_pending = r_bytes_pending - 3'd1;
        end
    end

    // Saturating positions: after this byte, and the declared end of a
    // sequence that the text cuts short.
    assign w_inc     = {1'b0, r_text_position} + (POSITION_BITS+1)'(1);
    assign w_pos     = w_inc[POSITION_BITS] ? POS_MAX : w_inc[POSITION_BITS-1:0];
    assign w_end_sum = {1'b0, r_text_position} + (POSITION_BITS+1)'(1)
                       + (POSITION_BITS+1)'(w_pending);
    assign w_end     = w_end_sum[POSITION_BITS] ? POS_MAX
                                                : w_end_sum[POSITION_BITS-1:0];

    assign w_complete = (w_pending == 3'd0) || w_eot;

    // A cut-short sequence fills its missing bytes with zero bits.
    logic [31:0] w_final_value;
    always_comb begin
        w_final_value = w_value;
        if (w_eot) begin
            case (w_pending)
                3'd1:    w_final_value = w_value << 6;
                3'd2:    w_final_value = w_value << 12;
                3'd3:    w_final_value = w_value << 18;
                3'd4:    w_final_value = w_value << 24;
                default: w_final_value = w_value;
            endcase
        end
    end

    // Match test and run split.
    assign w_match     = (w_final_value & r_match_mask) == r_match_code;
    assign w_split     = w_complete && r_first_done && (w_match != r_prior_match);
    assign w_run_begin = w_split ? w_point_begin : r_run_begin;
    assign w_prior     = w_complete ? w_match : r_prior_match;

    always_comb begin
        w_split_run.run_offset = 32'(r_run_begin);
        w_split_run.run_bytes  = 32'(w_point_begin - r_run_begin);
        w_split_run.run_tag    = r_prior_match ? r_range_flag : 32'h0;
        w_split_run.final_run  = 1'b0;
        w_final_run.run_offset = 32'(w_run_begin);
        w_final_run.run_bytes  = 32'(w_end - w_run_begin);
        w_final_run.run_tag    = w_prior ? r_range_flag : 32'h0;
        w_final_run.final_run  = 1'b1;
    end

    // Results for the queue, split run first.
    always_comb begin
        o_push.count  = 2'd0;
        o_push.first  = w_split ? w_split_run : w_final_run;
        o_push.second = w_final_run;
        if (w_proceed) begin
            o_push.count = 2'({1'b0, w_split} + {1'b0, w_eot});
        end
    end

    // Next state; the end of the text returns the text state to its reset values.
    always_comb begin
        n_text_position = r_text_position;
        n_run_begin     = r_run_begin;
        n_point_begin   = r_point_begin;
        n_point_value   = r_point_value;
        n_bytes_pending = r_bytes_pending;
        n_prior_match   = r_prior_match;
        n_first_done    = r_first_done;
        if (w_proceed) begin
            if (w_eot) begin
                n_text_position = '0;
                n_run_begin     = '0;
                n_point_begin   = '0;
                n_point_value   = '0;
                n_bytes_pending = 3'd0;
                n_prior_match   = 1'b0;
                n_first_done    = 1'b0;
            end else begin
                n_text_position = w_pos;
                n_run_begin     = w_run_begin;
                n_point_begin   = w_point_begin;
                n_point_value   = w_value;
                n_bytes_pending = w_pending;
                n_prior_match   = w_prior;
                n_first_done    = r_first_done || w_complete;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_position <= '0;
            r_run_begin     <= '0;
            r_point_begin   <= '0;
            r_point_value   <= '0;
            r_bytes_pending <= 3'd0;
            r_prior_match   <= 1'b0;
            r_first_done    <= 1'b0;
        end else begin
            r_text_position <= n_text_position;
            r_run_begin     <= n_run_begin;
            r_point_begin   <= n_point_begin;
            r_point_value   <= n_point_value;
            r_bytes_pending <= n_bytes_pending;
            r_prior_match   <= n_prior_match;
            r_first_done    <= n_first_done;
        end
    end

    // Two results come only from the last byte of a text.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (w_proceed && w_eot))
        else $error("two results from a byte that does not end the text");

    // The open run never starts after the current code point.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_begin <= r_point_begin)
        else $error("run start passed the code point start");

endmodule

FILE: hdl/u8rs_run_fifo.sv
// Result queue that takes up to two items per cycle and hands out one while the receiver does not stall.
// Depends on u8rs_pkg; filled by u8rs_decode.
module u8rs_run_fifo
    import u8rs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_room,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_out_item                 r_entry [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count, n_count;
    logic                      w_pop;
    logic [QUEUE_PTR_BITS-1:0] w_wr_next;

    // Room for two results is needed before a byte is processed.
    assign o_room      = r_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign o_out_item  = r_entry[r_rd_ptr];
    assign w_pop       = o_out_valid && !i_out_stall;
    assign w_wr_next   = r_wr_ptr + QUEUE_PTR_BITS'(1);

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr + QUEUE_PTR_BITS'(i_push.count);
        n_rd_ptr = w_pop ? r_rd_ptr + QUEUE_PTR_BITS'(1) : r_rd_ptr;
        n_count  = r_count + QUEUE_CNT_BITS'(i_push.count)
                   - QUEUE_CNT_BITS'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_entry[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_entry[w_wr_next] <= i_push.second;
        end
    end

    // Pushes never overrun the free entries.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} + 4'(i_push.count)) <= 4'(QUEUE_DEPTH))
        else $error("result queue overrun");

    // The fill count tracks the pointer distance.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == QUEUE_CNT_BITS'(QUEUE_DEPTH)) ||
        (QUEUE_PTR_BITS'(r_wr_ptr - r_rd_ptr) == r_count[QUEUE_PTR_BITS-1:0]))
        else $error("result queue count out of step with pointers");

endmodule

FILE: hdl/utf8_code_point_run_splitter.sv
// Top level of the UTF-8 code point run splitter.
// Depends on u8rs_pkg, u8rs_decode and u8rs_run_fifo.
//
// The input channel takes one text byte per item with an end-of-text mark.
// Each byte is decoded as UTF-8; every finished code point is tested
// against the match code and mask, and each change of the match result
// closes a run that leaves on the output channel as one item (offset,
// length, tag). The byte marked as end of text also sends the final run,
// so that byte can give two items; the text state then starts over.
// Configuration is written through its own valid/ready port, which is
// always ready; writes belong to times when no byte is in flight.
// A byte waits in the input register until the queue has room; when it is
// processed, its runs are written into the result queue. Bytes are taken one
// per cycle while the queue has room, as the decode step is combinational;
// the output hands out one item per cycle while the receiver does not stall.
// A four-entry result queue parts the channels: input stall rises only when
// the queue could not take two more items, so a stalled receiver fills
// the queue and then holds the sender. Reset is synchronous and empties
// the queue, clears the text state and zeroes the configuration.
module utf8_code_point_run_splitter
    import u8rs_pkg::*;
#(
    parameter int POSITION_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  t_in_item                  i_in_item,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_item                 o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [31:0]               i_cfg_data
);

    t_push w_push;
    logic  w_room;

    assign o_cfg_ready = 1'b1;

    // Decode and run tracking.
    u8rs_decode #(
        .POSITION_BITS (POSITION_BITS)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_room      (w_room),
        .o_push      (w_push)
    );

    // Result queue toward the receiver.
    u8rs_run_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_room      (w_room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
